// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque: command and status codes,
// and the control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

   // command codes
   localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
   localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
   localparam logic [1:0] CMD_POP_BACK   = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

   // field widths
   localparam int unsigned CmdWidth    = 2;
   localparam int unsigned WordWidth   = 32;
   localparam int unsigned StatWidth   = 2;
   localparam int unsigned ReqDataBits = 40;
   localparam int unsigned RspDataBits = 40;

   // controller to datapath
   typedef struct packed {
      logic accept;     // input transaction taken this cycle
      logic load_pop;   // ring read data is valid, capture popped word
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pop_read;   // current request is a pop that will read the ring
   } dp_stat_type;

endpackage : cdq_pkg

// ===== sv/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : cdq_ram

// ===== sv/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller: handshakes on both channels and sequences the ring read
// that a pop needs before its result can be shown.
// ----------------------------------------------------------------------------
module cdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output cdq_pkg::ctrl_cmd_type ctrl_cmd,
   input  cdq_pkg::dp_stat_type  dp_stat
);
   import cdq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // take a request when idle and the output register is free or draining
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign ctrl_cmd.accept   = accept;
   assign ctrl_cmd.load_pop = (state_ff == ST_READ);
   assign rsp_tvalid        = rsp_valid_ff;

   // next state and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (dp_stat.pop_read) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule : cdq_ctrl

// ===== sv/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// cdq_datapath
// Datapath: head and tail indices, empty flag, the ring memory and the
// result register.
// ----------------------------------------------------------------------------
module cdq_datapath #(
   parameter int unsigned DEPTH = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [cdq_pkg::CmdWidth-1:0]          cmd,
   input  logic signed [cdq_pkg::WordWidth-1:0]  value,
   input  cdq_pkg::ctrl_cmd_type                 ctrl_cmd,
   output cdq_pkg::dp_stat_type                  dp_stat,
   output logic signed [cdq_pkg::WordWidth-1:0]  popped_value,
   output logic [cdq_pkg::StatWidth-1:0]         status,
   output logic                                  is_empty,
   output logic                                  is_full
);
   import cdq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic          empty_ff, empty_in;

   logic signed [WordWidth-1:0] popped_ff;
   logic [StatWidth-1:0]        status_ff, status_in;
   logic                        is_empty_ff;
   logic                        is_full_ff, full_in;

   logic                 is_push, full_now, push_ok, pop_ok;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WordWidth-1:0] rd_data;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
      return (i == LastIdx) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
      return (i == '0) ? LastIdx : i - AW'(1);
   endfunction

   // decode against current occupancy
   assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
   assign full_now = !empty_ff && (head_ff == wrap_inc(tail_ff));
   assign push_ok  = is_push && !full_now;
   assign pop_ok   = !is_push && !empty_ff;

   assign dp_stat.pop_read = pop_ok;

   // index update and ring write address
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      wr_addr   = '0;
      status_in = STAT_DONE;
      if (is_push) begin
         if (full_now) begin
            status_in = STAT_OVERFLOW;
         end else if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
         end else if (cmd == CMD_PUSH_FRONT) begin
            head_in = wrap_dec(head_ff);
            wr_addr = head_in;
         end else begin
            tail_in = wrap_inc(tail_ff);
            wr_addr = tail_in;
         end
      end else begin
         if (empty_ff) begin
            status_in = STAT_UNDERFLOW;
         end else if (head_ff == tail_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b1;
         end else if (cmd == CMD_POP_FRONT) begin
            head_in = wrap_inc(head_ff);
         end else begin
            tail_in = wrap_dec(tail_ff);
         end
      end
      full_in = !empty_in && (head_in == wrap_inc(tail_in));
   end

   assign rd_addr = (cmd == CMD_POP_FRONT) ? head_ff : tail_ff;
   assign wr_en   = ctrl_cmd.accept && push_ok;

   cdq_ram #(
      .WIDTH (WordWidth),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value),
      .rd_en   (ctrl_cmd.accept && pop_ok),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // deque state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (ctrl_cmd.accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   // result register; popped word is captured from the registered ring read data in ST_READ
   always_ff @(posedge clock) begin
      if (ctrl_cmd.accept) begin
         popped_ff   <= '0;
         status_ff   <= status_in;
         is_empty_ff <= empty_in;
         is_full_ff  <= full_in;
      end else if (ctrl_cmd.load_pop) begin
         popped_ff <= rd_data;
      end
   end

   assign popped_value = popped_ff;
   assign status       = status_ff;
   assign is_empty     = is_empty_ff;
   assign is_full      = is_full_ff;

endmodule : cdq_datapath

// ===== sv/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words held in a ring of DEPTH slots.
//
//   channel | direction | tdata fields (low bit first)
//   req_    | in        | cmd[1:0], value[33:2], zero pad to 40 bits
//   rsp_    | out       | popped_value[31:0], status[33:32], is_empty[34],
//           |           | is_full[35], zero pad to 40 bits
//
// A push or a rejected command shows its result in the cycle after it is
// taken. A successful pop also waits on the registered ring RAM read.
// Requests are taken while the result register is empty or being drained
// and no pop read is pending, so a pop blocks the request side meanwhile.
// Reset empties the deque at once; no clearing pass over the ring.
// rsp_tready low holds the result and stalls the request side.
// ----------------------------------------------------------------------------
module circular_deque #(
   parameter int unsigned DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cdq_pkg::ReqDataBits-1:0]     req_tdata,  // cmd, value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cdq_pkg::RspDataBits-1:0]     rsp_tdata   // popped_value, status,
                                                           // is_empty, is_full
);
   import cdq_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   logic [CmdWidth-1:0]         cmd;
   logic signed [WordWidth-1:0] value;
   logic signed [WordWidth-1:0] popped_value;
   logic [StatWidth-1:0]        status;
   logic                        is_empty;
   logic                        is_full;

   // unpack request
   assign cmd   = req_tdata[CmdWidth-1:0];
   assign value = req_tdata[CmdWidth+WordWidth-1:CmdWidth];

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl_cmd   (ctrl_cmd),
      .dp_stat    (dp_stat)
   );

   cdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .value        (value),
      .ctrl_cmd     (ctrl_cmd),
      .dp_stat      (dp_stat),
      .popped_value (popped_value),
      .status       (status),
      .is_empty     (is_empty),
      .is_full      (is_full)
   );

   // pack response
   assign rsp_tdata = {4'b0000, is_full, is_empty, status, popped_value};

endmodule : circular_deque
